>>> hdl/lsfc_pkg.sv
// Shared types, constants and a helper function for the LED scanner fade controller.
`default_nettype none

package lsfc_pkg;

    // Widths of the payload and state fields.
    localparam int ADC_W    = 8;
    localparam int LEVEL_W  = 8;
    localparam int TICKS_W  = 16;
    localparam int MODE_W   = 4;
    localparam int SPEED_W  = 11;
    localparam int PROD_W   = TICKS_W + SPEED_W;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_BRIGHTNESS = 2'd2;

    // Configuration reset values.
    localparam logic [TICKS_W-1:0] THRESHOLD_RESET = 16'd250;
    localparam logic [7:0]         DEBOUNCE_RESET  = 8'd20;
    localparam logic [LEVEL_W-1:0] PEAK_RESET      = 8'h8f;

    // Mode range and LED patterns.
    localparam logic [MODE_W-1:0] MODE_MAX = 4'd9;
    localparam logic [MODE_W-1:0] MODE_ALL = 4'd0;
    localparam logic [MODE_W-1:0] MODE_HALF = 4'd1;
    localparam logic [MODE_W-1:0] MODE_PAIRS = 4'd2;

    localparam logic [7:0] PAT_ALL    = 8'hff;
    localparam logic [7:0] PAT_HALF_A = 8'hf0;
    localparam logic [7:0] PAT_HALF_B = 8'h0f;
    localparam logic [7:0] PAT_PAIR_A = 8'b11001100;
    localparam logic [7:0] PAT_PAIR_B = 8'b00110011;
    localparam logic [7:0] PAT_ODD_A  = 8'b10101010;
    localparam logic [7:0] PAT_ODD_B  = 8'b01010101;

    // Beep codes, also used to tell which button was pressed.
    typedef enum logic [1:0] {
        BEEP_NONE       = 2'd0,
        BEEP_START_STOP = 2'd1,
        BEEP_DOWN       = 2'd2,
        BEEP_UP         = 2'd3
    } beep_t;

    // Configuration registers.
    typedef struct packed {
        logic [TICKS_W-1:0] step_threshold;
        logic [7:0]         debounce_limit;
        logic [LEVEL_W-1:0] peak_brightness;
    } cfg_t;

    // Controller state carried from tick to tick.
    typedef struct packed {
        logic [7:0]         hold_count;
        logic               press_lock;
        logic [MODE_W-1:0]  mode;
        logic               stopped;
        logic [LEVEL_W-1:0] ramp_level;
        logic [TICKS_W-1:0] ramp_ticks;
        logic               ramp_down;
        logic               alternate;
        logic [7:0]         pattern;
        logic [LEVEL_W-1:0] duty;
    } state_t;

    // Speed from the pot sample: ((adc * 100) / 255) * 10 + 10.
    // The divide by 255 is (x + 1) * 257 >> 16, exact for x up to 255 * 257.
    function automatic logic [SPEED_W-1:0] speed_of(input logic [ADC_W-1:0] adc);
        logic [14:0] scaled;
        logic [22:0] recip;
        logic [6:0]  quot;
        logic [SPEED_W-1:0] speed;
        scaled = 15'(adc) * 15'd100;
        recip  = (23'(scaled) + 23'd1) * 23'd257;
        quot   = recip[22:16];
        speed  = SPEED_W'(quot) * SPEED_W'(10) + SPEED_W'(10);
        return speed;
    endfunction

endpackage

`default_nettype wire

>>> hdl/lsfc_tick.sv
// Next-state logic for one control tick: debounce, mode and run control, ramp and pattern.
`default_nettype none

module lsfc_tick (
    input  wire lsfc_pkg::state_t                 st,
    input  wire lsfc_pkg::cfg_t                   cfg,
    input  wire logic [lsfc_pkg::SPEED_W-1:0]     speed,
    input  wire logic                             btn_one,
    input  wire logic                             btn_two,
    input  wire logic                             btn_three,
    output lsfc_pkg::state_t                      st_next,
    output lsfc_pkg::beep_t                       beep
);
    import lsfc_pkg::*;

    logic                all_released;
    logic                multi_held;
    beep_t               which;
    logic                hold_over;
    logic [PROD_W-1:0]   product;
    logic                over;

    // Button decode: the lock needs all three released, two or more held only lock.
    assign all_released = btn_one & btn_two & btn_three;
    assign multi_held   = (!btn_one && !btn_two) || (!btn_one && !btn_three)
                       || (!btn_two && !btn_three);
    assign hold_over    = st.hold_count > cfg.debounce_limit;

    always_comb
    begin
        if (!btn_one) begin
            which = BEEP_START_STOP;
        end else if (!btn_two) begin
            which = BEEP_DOWN;
        end else if (!btn_three) begin
            which = BEEP_UP;
        end else begin
            which = BEEP_NONE;
        end
    end

    // Debounce and press handling, then the ramp on the updated state.
    always_comb
    begin
        st_next = st;
        beep    = BEEP_NONE;

        if (st.press_lock) begin
            if (!all_released) begin
                st_next.hold_count = '0;
            end else if (hold_over) begin
                st_next.hold_count = '0;
                st_next.press_lock = 1'b0;
            end else begin
                st_next.hold_count = st.hold_count + 8'd1;
            end
        end else if (multi_held) begin
            st_next.press_lock = 1'b1;
        end else if (which == BEEP_NONE) begin
            st_next.hold_count = '0;
        end else if (hold_over) begin
            st_next.hold_count = '0;
            st_next.press_lock = 1'b1;
            st_next.ramp_ticks = '0;
            st_next.ramp_level = '0;
            st_next.ramp_down  = 1'b0;
            beep = which;
            case (which)
                BEEP_START_STOP: begin
                    st_next.alternate = 1'b0;
                    st_next.duty      = '0;
                    st_next.stopped   = !st.stopped;
                end
                BEEP_DOWN: begin
                    st_next.mode = (st.mode == '0) ? MODE_MAX : st.mode - 4'd1;
                end
                default: begin
                    st_next.mode = (st.mode == MODE_MAX) ? '0 : st.mode + 4'd1;
                end
            endcase
        end else begin
            st_next.hold_count = st.hold_count + 8'd1;
        end

        // The step product is taken at full width so it never wraps.
        product = PROD_W'(st_next.ramp_ticks) * PROD_W'(speed);
        over    = product > PROD_W'(cfg.step_threshold);

        if (!st_next.stopped) begin
            if (!st_next.ramp_down) begin
                if (st_next.ramp_level == cfg.peak_brightness) begin
                    st_next.ramp_down = 1'b1;
                end else if (over) begin
                    st_next.ramp_level = st_next.ramp_level + 8'd1;
                    st_next.ramp_ticks = '0;
                end else begin
                    st_next.ramp_ticks = st_next.ramp_ticks + 16'd1;
                end
            end else begin
                if (st_next.ramp_level == '0) begin
                    st_next.ramp_down = 1'b0;
                    st_next.alternate = !st_next.alternate;
                end else if (over) begin
                    st_next.ramp_level = st_next.ramp_level - 8'd1;
                    st_next.ramp_ticks = '0;
                end else begin
                    st_next.ramp_ticks = st_next.ramp_ticks + 16'd1;
                end
            end

            case (st_next.mode)
                MODE_ALL:   st_next.pattern = PAT_ALL;
                MODE_HALF:  st_next.pattern = st_next.alternate ? PAT_HALF_B : PAT_HALF_A;
                MODE_PAIRS: st_next.pattern = st_next.alternate ? PAT_PAIR_B : PAT_PAIR_A;
                default:    st_next.pattern = st_next.alternate ? PAT_ODD_B : PAT_ODD_A;
            endcase
            st_next.duty = st_next.ramp_level;
        end
    end

endmodule

`default_nettype wire

>>> hdl/led_scanner_fade_controller.sv
// Top level of the LED scanner fade controller: handshakes, configuration and state registers.
//
// Each input item is one control tick: a speed pot sample and three active-low
// button levels. It is taken on a rising edge with in_valid high and in_stall
// low. Every item gives exactly one result item (pattern, brightness, beep
// code, dark flag and mode) on the output channel, taken when out_valid is
// high and out_stall low.
// The path is two registers deep: the first stage captures the item and works
// out the speed from the pot sample, the second runs the debounce, mode and
// ramp update and holds the result. An accepted item moves on from the input
// stage when the result stage is free, and out_valid then rises with its result;
// one item is taken every cycle while the output flows.
// While out_stall holds a waiting result, one more item can sit in the input
// stage; after that in_stall rises until the result is taken. A held result
// does not change.
// Configuration writes go through cfg_write, cfg_index and cfg_data and must be
// made only while the block is idle, which the block itself does not enforce;
// an index past the last register is ignored. Reset clears all controller state,
// empties both stages and loads the default threshold, debounce limit and peak brightness.
`default_nettype none

module led_scanner_fade_controller (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [lsfc_pkg::ADC_W-1:0]       adc_level,
    input  wire logic                             button_one,
    input  wire logic                             button_two,
    input  wire logic                             button_three,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [7:0]                            led_pattern,
    output logic [lsfc_pkg::LEVEL_W-1:0]          brightness,
    output logic [1:0]                            beep_code,
    output logic                                  dark,
    output logic [lsfc_pkg::MODE_W-1:0]           mode_now,
    input  wire logic                             cfg_write,
    input  wire logic [lsfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lsfc_pkg::CFG_W-1:0]       cfg_data
);
    import lsfc_pkg::*;

    cfg_t               cfg_reg;
    state_t             st_reg;
    state_t             st_next;
    beep_t              beep_reg;
    beep_t              beep_next;
    logic               stage_valid_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic               btn_one_reg;
    logic               btn_two_reg;
    logic               btn_three_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               take_in;

    // The result stage moves when it is empty or its item is being taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = stage_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.step_threshold  <= THRESHOLD_RESET;
            cfg_reg.debounce_limit  <= DEBOUNCE_RESET;
            cfg_reg.peak_brightness <= PEAK_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_STEP_THRESHOLD:  cfg_reg.step_threshold  <= cfg_data;
                CFG_DEBOUNCE_LIMIT:  cfg_reg.debounce_limit  <= cfg_data[7:0];
                CFG_PEAK_BRIGHTNESS: cfg_reg.peak_brightness <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Input stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
        end else if (take_in) begin
            stage_valid_reg <= 1'b1;
        end else if (advance) begin
            stage_valid_reg <= 1'b0;
        end
    end

    // Input stage payload: buttons and the speed derived from the pot sample.
    always_ff @(posedge clk)
    begin
        if (take_in) begin
            speed_reg     <= speed_of(adc_level);
            btn_one_reg   <= button_one;
            btn_two_reg   <= button_two;
            btn_three_reg <= button_three;
        end
    end

    lsfc_tick u_tick (
        .st        (st_reg),
        .cfg       (cfg_reg),
        .speed     (speed_reg),
        .btn_one   (btn_one_reg),
        .btn_two   (btn_two_reg),
        .btn_three (btn_three_reg),
        .st_next   (st_next),
        .beep      (beep_next)
    );

    // Controller state and result stage; the state doubles as the result payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg        <= '0;
            beep_reg      <= BEEP_NONE;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= stage_valid_reg;
            if (stage_valid_reg) begin
                st_reg   <= st_next;
                beep_reg <= beep_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign led_pattern = st_reg.pattern;
    assign brightness  = st_reg.duty;
    assign beep_code   = beep_reg;
    assign dark        = st_reg.stopped;
    assign mode_now    = st_reg.mode;

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the LED scanner fade controller: predictor, scoreboard and stimulus.
module tb;
    import lsfc_pkg::*;

    // Settings after reset and the top mode, kept apart from the design's copies.
    localparam logic [15:0] THRESHOLD_AT_RESET = 16'd250;
    localparam logic [7:0]  LIMIT_AT_RESET     = 8'd20;
    localparam logic [7:0]  PEAK_AT_RESET      = 8'h8f;
    localparam logic [3:0]  TOP_MODE           = 4'd9;

    // Button masks: a set bit means that button is held down.
    localparam logic [2:0] PRESS_NONE  = 3'b000;
    localparam logic [2:0] PRESS_ONE   = 3'b001;
    localparam logic [2:0] PRESS_TWO   = 3'b010;
    localparam logic [2:0] PRESS_THREE = 3'b100;
    localparam logic [2:0] ALL_UP      = 3'b111;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [7:0] pattern;
        logic [7:0] level;
        logic [1:0] beep;
        logic       dark;
        logic [3:0] mode;
    } led_frame_t;

    // Tracks the controller state, predicts each frame and checks what comes out.
    class scanner_scoreboard;
        logic [15:0] step_threshold;
        logic [7:0]  debounce_limit;
        logic [7:0]  peak_level;
        logic [7:0]  hold_count;
        bit          press_lock;
        logic [3:0]  mode;
        bit          stopped;
        logic [7:0]  ramp_level;
        logic [15:0] ramp_ticks;
        bit          ramp_down;
        bit          alternate;
        logic [7:0]  pattern;
        logic [7:0]  duty;
        led_frame_t  expected_frames[$];
        int          errors;

        function new();
            step_threshold = THRESHOLD_AT_RESET;
            debounce_limit = LIMIT_AT_RESET;
            peak_level     = PEAK_AT_RESET;
            hold_count     = '0;
            press_lock     = 1'b0;
            mode           = '0;
            stopped        = 1'b0;
            ramp_level     = '0;
            ramp_ticks     = '0;
            ramp_down      = 1'b0;
            alternate      = 1'b0;
            pattern        = '0;
            duty           = '0;
            errors         = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [15:0] value);
            case (index)
                CFG_STEP_THRESHOLD:  step_threshold = value;
                CFG_DEBOUNCE_LIMIT:  debounce_limit = value[7:0];
                CFG_PEAK_BRIGHTNESS: peak_level     = value[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        // Advance the model by one accepted tick and queue the frame it yields.
        function void note_tick(logic [7:0] adc, logic b1, logic b2, logic b3);
            int unsigned speed;
            int unsigned product;
            int          released;
            bit          over;
            beep_t       pressed;
            beep_t       beep;
            led_frame_t  frame;
            speed    = ((int'(adc) * 100) / 255) * 10 + 10;
            released = int'(b1) + int'(b2) + int'(b3);
            pressed  = BEEP_NONE;
            beep     = BEEP_NONE;

            // Debounce: a locked controller waits for a clean release.
            if (press_lock) begin
                if (released < 3) begin
                    hold_count = '0;
                end else if (hold_count > debounce_limit) begin
                    hold_count = '0;
                    press_lock = 1'b0;
                end else begin
                    hold_count = hold_count + 8'd1;
                end
            end else if (released < 2) begin
                press_lock = 1'b1;
            end else begin
                if (!b1) pressed = BEEP_START_STOP;
                else if (!b2) pressed = BEEP_DOWN;
                else if (!b3) pressed = BEEP_UP;
                if (pressed == BEEP_NONE) begin
                    hold_count = '0;
                end else if (hold_count > debounce_limit) begin
                    hold_count = '0;
                    press_lock = 1'b1;
                    ramp_ticks = '0;
                    ramp_level = '0;
                    ramp_down  = 1'b0;
                    beep       = pressed;
                    if (pressed == BEEP_START_STOP) begin
                        alternate = 1'b0;
                        duty      = '0;
                        stopped   = !stopped;
                    end else if (pressed == BEEP_DOWN) begin
                        mode = (mode == 4'd0) ? TOP_MODE : mode - 4'd1;
                    end else begin
                        mode = (mode == TOP_MODE) ? 4'd0 : mode + 4'd1;
                    end
                end else begin
                    hold_count = hold_count + 8'd1;
                end
            end

            // Brightness ramp and pattern, frozen while dark.
            if (!stopped) begin
                product = ramp_ticks * speed;
                over    = product > step_threshold;
                if (!ramp_down) begin
                    if (ramp_level == peak_level) begin
                        ramp_down = 1'b1;
                    end else if (over) begin
                        ramp_level = ramp_level + 8'd1;
                        ramp_ticks = '0;
                    end else begin
                        ramp_ticks = ramp_ticks + 16'd1;
                    end
                end else begin
                    if (ramp_level == 8'd0) begin
                        ramp_down = 1'b0;
                        alternate = !alternate;
                    end else if (over) begin
                        ramp_level = ramp_level - 8'd1;
                        ramp_ticks = '0;
                    end else begin
                        ramp_ticks = ramp_ticks + 16'd1;
                    end
                end
                case (mode)
                    4'd0:    pattern = 8'hff;
                    4'd1:    pattern = alternate ? 8'h0f : 8'hf0;
                    4'd2:    pattern = alternate ? 8'h33 : 8'hcc;
                    default: pattern = alternate ? 8'h55 : 8'haa;
                endcase
                duty = ramp_level;
            end

            frame.pattern = pattern;
            frame.level   = duty;
            frame.beep    = beep;
            frame.dark    = stopped;
            frame.mode    = mode;
            expected_frames.push_back(frame);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        // Compare one output frame with the oldest prediction.
        function void check_frame(led_frame_t got);
            led_frame_t want;
            if (expected_frames.size() == 0) begin
                errors++;
                $display("%0t: unexpected frame %0h, none predicted", $time, got);
                return;
            end
            want = expected_frames.pop_front();
            compare_field("led_pattern", 16'(want.pattern), 16'(got.pattern));
            compare_field("brightness", 16'(want.level), 16'(got.level));
            compare_field("beep_code", 16'(want.beep), 16'(got.beep));
            compare_field("dark", 16'(want.dark), 16'(got.dark));
            compare_field("mode_now", 16'(want.mode), 16'(got.mode));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  adc_level;
    logic        button_one;
    logic        button_two;
    logic        button_three;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  led_pattern;
    logic [7:0]  brightness;
    logic [1:0]  beep_code;
    logic        dark;
    logic [3:0]  mode_now;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    scanner_scoreboard sb;
    led_frame_t        seen_frame;
    int                ticks_sent;
    bit                gaps_on;
    bit                stall_on;
    bit                hold_req;
    int                phase_start;

    led_scanner_fade_controller u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .adc_level    (adc_level),
        .button_one   (button_one),
        .button_two   (button_two),
        .button_three (button_three),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .led_pattern  (led_pattern),
        .brightness   (brightness),
        .beep_code    (beep_code),
        .dark         (dark),
        .mode_now     (mode_now),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #1000000;
        $display("tb: errors");
        $finish;
    end

    // Check every frame taken from the output.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            seen_frame = {led_pattern, brightness, beep_code, dark, mode_now};
            sb.check_frame(seen_frame);
        end
    end

    // Output back-pressure: random bursts, plus one long hold on request.
    initial
    begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (60) @(negedge clk);
                out_stall <= 1'b0;
            end else if (stall_on && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Pot samples lean toward the extremes now and then.
    function automatic logic [7:0] pick_adc();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one tick and wait until it is taken; called and returns at a falling edge.
    task automatic send_tick(input logic [7:0] adc, input logic [2:0] levels);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        adc_level    <= adc;
        button_one   <= levels[0];
        button_two   <= levels[1];
        button_three <= levels[2];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_tick(adc, levels[0], levels[1], levels[2]);
        ticks_sent++;
        @(negedge clk);
    endtask

    // Hold the given buttons for some ticks, then release them all.
    task automatic push_button(input logic [2:0] held, input int hold_ticks,
                               input int rest_ticks);
        repeat (hold_ticks) send_tick(pick_adc(), ~held);
        repeat (rest_ticks) send_tick(pick_adc(), ALL_UP);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        sb.set_register(index, value);
    endtask

    // Reprogram all three registers once the block has gone quiet.
    // The upper byte of the 8-bit registers carries junk that must be dropped.
    task automatic load_settings(input logic [15:0] threshold, input logic [7:0] limit,
                                 input logic [7:0] peak);
        wait_for_results();
        repeat (3) @(negedge clk);
        write_register(CFG_STEP_THRESHOLD, threshold);
        write_register(CFG_DEBOUNCE_LIMIT, {8'($urandom), limit});
        write_register(CFG_PEAK_BRIGHTNESS, {8'($urandom), peak});
    endtask

    // Mostly clean press and release sequences, with early releases, chords and noise.
    task automatic run_sequences(input int lim, input int last);
        int          kind;
        int          hold;
        int          rest;
        logic [2:0]  held;
        while (ticks_sent < last) begin
            kind = $urandom_range(0, 9);
            hold = lim + 2 + $urandom_range(0, 3);
            rest = lim + 2 + $urandom_range(0, 3);
            held = PRESS_ONE << $urandom_range(0, 2);
            if (kind < 6) begin
                push_button(held, hold, rest);
            end else if (kind == 6) begin
                push_button(held, $urandom_range(1, lim + 1), $urandom_range(1, rest));
            end else if (kind == 7) begin
                held = ~(PRESS_ONE << $urandom_range(0, 3));
                push_button(held, $urandom_range(1, 4), rest);
            end else begin
                repeat ($urandom_range(1, 4)) send_tick(pick_adc(), 3'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        adc_level    = '0;
        button_one   = 1'b1;
        button_two   = 1'b1;
        button_three = 1'b1;
        cfg_write    = 1'b0;
        cfg_index    = CFG_STEP_THRESHOLD;
        cfg_data     = '0;
        ticks_sent   = 0;
        gaps_on      = 1'b1;
        stall_on     = 1'b1;
        hold_req     = 1'b0;
        sb           = new();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: pot extremes, a two-button chord and all three under reset settings.
        send_tick(8'h00, ALL_UP);
        send_tick(8'hff, ALL_UP);
        send_tick(8'h80, ~(PRESS_ONE | PRESS_TWO));
        send_tick(8'h7f, ~ALL_UP);

        // Directed: short debounce, mode down from 0 wraps to 9, up wraps back, then stop.
        load_settings(16'd0, 8'd1, 8'd2);
        push_button(PRESS_NONE, 0, 3);
        push_button(PRESS_TWO, 3, 3);
        push_button(PRESS_THREE, 3, 3);
        push_button(PRESS_ONE, 3, 3);

        // Reset values written back; the sender pauses halfway until all frames are out.
        load_settings(THRESHOLD_AT_RESET, LIMIT_AT_RESET, PEAK_AT_RESET);
        phase_start = ticks_sent;
        run_sequences(20, phase_start + 60);
        wait_for_results();
        run_sequences(20, phase_start + 110);

        // Fastest debounce and lowest peak; the output holds off for a long stretch.
        load_settings(16'd0, 8'd0, 8'd1);
        phase_start = ticks_sent;
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        run_sequences(0, phase_start + 110);
        gaps_on = 1'b1;

        // Slowest ramp and highest peak.
        load_settings(16'hffff, 8'd3, 8'hff);
        phase_start = ticks_sent;
        run_sequences(3, phase_start + 70);

        // Let the ramp climb while scanning, restarting first if the block is dark.
        load_settings(16'd0, 8'd0, 8'hff);
        phase_start = ticks_sent;
        push_button(PRESS_NONE, 0, 2);
        if (sb.stopped) push_button(PRESS_ONE, 2, 2);
        push_button(PRESS_NONE, 0, phase_start + 46 - ticks_sent);

        // Peak dropped below the level: the ramp wraps through 255. A debounce limit
        // of 255 never accepts, so a long hold wraps the hold counter too.
        load_settings(16'd0, 8'hff, 8'd10);
        phase_start = ticks_sent;
        push_button(PRESS_TWO, 300, 0);
        while (ticks_sent < phase_start + 380) send_tick(pick_adc(), 3'($urandom));
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        while (ticks_sent < phase_start + 530) send_tick(pick_adc(), 3'($urandom));

        wait_for_results();
        repeat (4) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

>>> led_scanner_fade_controller.f
hdl/lsfc_pkg.sv
hdl/lsfc_tick.sv
hdl/led_scanner_fade_controller.sv
dv/tb.sv
